// ===== rtl/iia_pkg.sv =====
`default_nettype none

package iia_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned FuncW  = 4;
    localparam int unsigned ErrW   = 2;

    localparam logic [FuncW-1:0] FnCopy      = 4'd0;
    localparam logic [FuncW-1:0] FnNegate    = 4'd1;
    localparam logic [FuncW-1:0] FnAdd       = 4'd2;
    localparam logic [FuncW-1:0] FnSubtract  = 4'd3;
    localparam logic [FuncW-1:0] FnMultiply  = 4'd4;
    localparam logic [FuncW-1:0] FnEqual     = 4'd5;
    localparam logic [FuncW-1:0] FnNotEqual  = 4'd6;
    localparam logic [FuncW-1:0] FnElement   = 4'd7;
    localparam logic [FuncW-1:0] FnConstruct = 4'd8;

    localparam logic [ErrW-1:0] ErrNone     = 2'd0;
    localparam logic [ErrW-1:0] ErrIndex    = 2'd1;
    localparam logic [ErrW-1:0] ErrHeadTail = 2'd2;

    typedef logic signed [WordW-1:0] t_word;

    typedef struct packed {
        logic [FuncW-1:0] func;
        t_word            a_lo;
        t_word            a_hi;
        t_word            b_lo;
        t_word            b_hi;
        t_word            index;
    } t_req;

    typedef struct packed {
        t_word           res_lo;
        t_word           res_hi;
        logic            truth;
        logic [ErrW-1:0] error;
    } t_res;

    // four wrapped endpoint products, or the finished result of any other op
    typedef struct packed {
        logic  is_mul;
        t_word p0;
        t_word p1;
        t_word p2;
        t_word p3;
        t_res  alt;
    } t_mid;

    typedef struct packed {
        logic  is_mul;
        t_word min01;
        t_word max01;
        t_word min23;
        t_word max23;
        t_res  alt;
    } t_part;

endpackage

`default_nettype wire

// ===== rtl/iia_front.sv =====
`default_nettype none

module iia_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire iia_pkg::t_req  i_req,
    output logic                o_valid,
    input  wire                 i_ready,
    output iia_pkg::t_mid       o_mid
);

    logic                r_a_v;
    iia_pkg::t_req       r_a;
    logic                r_b_v;
    iia_pkg::t_mid       r_b;
    iia_pkg::t_mid       n_b;
    logic                a_load;
    logic                b_load;
    logic signed [32:0]  width;
    logic                idx_bad;

    assign b_load  = !r_b_v || i_ready;
    assign a_load  = !r_a_v || b_load;
    assign o_ready = a_load;
    assign o_valid = r_b_v;
    assign o_mid   = r_b;

    assign width   = 33'(r_a.a_hi) - 33'(r_a.a_lo);
    assign idx_bad = r_a.index[31] || (33'(r_a.index) > width);

    always_comb begin
        n_b        = '0;
        n_b.p0     = iia_pkg::t_word'(r_a.a_lo * r_a.b_lo);
        n_b.p1     = iia_pkg::t_word'(r_a.a_lo * r_a.b_hi);
        n_b.p2     = iia_pkg::t_word'(r_a.a_hi * r_a.b_lo);
        n_b.p3     = iia_pkg::t_word'(r_a.a_hi * r_a.b_hi);
        case (r_a.func)
            iia_pkg::FnCopy: begin
                n_b.alt.res_lo = r_a.a_lo;
                n_b.alt.res_hi = r_a.a_hi;
            end
            iia_pkg::FnNegate: begin
                n_b.alt.res_lo = -r_a.a_hi;
                n_b.alt.res_hi = -r_a.a_lo;
            end
            iia_pkg::FnAdd: begin
                n_b.alt.res_lo = r_a.a_lo + r_a.b_lo;
                n_b.alt.res_hi = r_a.a_hi + r_a.b_hi;
            end
            iia_pkg::FnSubtract: begin
                n_b.alt.res_lo = r_a.a_lo - r_a.b_hi;
                n_b.alt.res_hi = r_a.a_hi - r_a.b_lo;
            end
            iia_pkg::FnMultiply: begin
                n_b.is_mul = 1'b1;
            end
            iia_pkg::FnEqual: begin
                n_b.alt.truth = (r_a.a_lo == r_a.b_lo) && (r_a.a_hi == r_a.b_hi);
            end
            iia_pkg::FnNotEqual: begin
                n_b.alt.truth = !((r_a.a_lo == r_a.b_lo) && (r_a.a_hi == r_a.b_hi));
            end
            iia_pkg::FnElement: begin
                if (idx_bad) begin
                    n_b.alt.error = iia_pkg::ErrIndex;
                end else begin
                    n_b.alt.res_lo = r_a.a_lo + r_a.index;
                end
            end
            iia_pkg::FnConstruct: begin
                if (r_a.a_lo > r_a.a_hi) begin
                    n_b.alt.error = iia_pkg::ErrHeadTail;
                end else begin
                    n_b.alt.res_lo = r_a.a_lo;
                    n_b.alt.res_hi = r_a.a_hi;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (a_load) begin
                r_a_v <= i_valid;
            end
            if (b_load) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load && i_valid) begin
            r_a <= i_req;
        end
        if (b_load && r_a_v) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/iia_reduce.sv =====
`default_nettype none

module iia_reduce (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire iia_pkg::t_mid  i_mid,
    output logic                o_valid,
    input  wire                 i_ready,
    output iia_pkg::t_res       o_res
);

    logic                r_c_v;
    iia_pkg::t_part      r_c;
    iia_pkg::t_part      n_c;
    logic                r_d_v;
    iia_pkg::t_res       r_d;
    iia_pkg::t_res       n_d;
    logic                c_load;
    logic                d_load;

    assign d_load  = !r_d_v || i_ready;
    assign c_load  = !r_c_v || d_load;
    assign o_ready = c_load;
    assign o_valid = r_d_v;
    assign o_res   = r_d;

    always_comb begin
        n_c.is_mul = i_mid.is_mul;
        n_c.alt    = i_mid.alt;
        n_c.min01  = (i_mid.p0 < i_mid.p1) ? i_mid.p0 : i_mid.p1;
        n_c.max01  = (i_mid.p0 > i_mid.p1) ? i_mid.p0 : i_mid.p1;
        n_c.min23  = (i_mid.p2 < i_mid.p3) ? i_mid.p2 : i_mid.p3;
        n_c.max23  = (i_mid.p2 > i_mid.p3) ? i_mid.p2 : i_mid.p3;
    end

    always_comb begin
        if (r_c.is_mul) begin
            n_d.res_lo = (r_c.min01 < r_c.min23) ? r_c.min01 : r_c.min23;
            n_d.res_hi = (r_c.max01 > r_c.max23) ? r_c.max01 : r_c.max23;
            n_d.truth  = 1'b0;
            n_d.error  = iia_pkg::ErrNone;
        end else begin
            n_d = r_c.alt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (c_load) begin
                r_c_v <= i_valid;
            end
            if (d_load) begin
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load && i_valid) begin
            r_c <= n_c;
        end
        if (d_load && r_c_v) begin
            r_d <= n_d;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/integer_interval_alu_top.sv =====
`default_nettype none

// Interval arithmetic unit: copy, negate, add, subtract, multiply, equal,
// not equal, element-at-index and construct on 32-bit signed closed intervals.
// Sums, differences and products wrap to 32 bits; the element index check
// uses the exact interval width. Four register stages (input, the four
// parallel 32x32 endpoint multipliers, pairwise min/max, final min/max and
// result select); one item is accepted every cycle while the output is not
// stalled. Each stage fills whenever it is empty, so bubbles close up under
// output backpressure; s_tready depends combinationally on m_tready.
module integer_interval_alu_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [159:0] i_s_tdata,   // a_lo, a_hi, b_lo, b_hi, index
    input  wire  [3:0]   i_s_tuser,   // func
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [71:0]  o_m_tdata    // res_lo, res_hi, truth, error, zero pad
);

    iia_pkg::t_req  req;
    iia_pkg::t_mid  mid;
    iia_pkg::t_res  res;
    logic           mid_valid;
    logic           mid_ready;

    assign req.func  = i_s_tuser;
    assign req.a_lo  = i_s_tdata[31:0];
    assign req.a_hi  = i_s_tdata[63:32];
    assign req.b_lo  = i_s_tdata[95:64];
    assign req.b_hi  = i_s_tdata[127:96];
    assign req.index = i_s_tdata[159:128];

    iia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_req   (req),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    iia_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {5'b0, res.error, res.truth, res.res_hi, res.res_lo};

endmodule

`default_nettype wire
